@@ rtl/date_add_days_weekday_core_assert.svh @@
// Assertion macros for the date shifter checker.
// Included by the checker file; depends on nothing else.
`ifndef DATE_ADD_DAYS_WEEKDAY_CORE_ASSERT_SVH
`define DATE_ADD_DAYS_WEEKDAY_CORE_ASSERT_SVH

// same-cycle implication
`define DADW_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DADW_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dadw_pkg.sv @@
// Shared types, constants and calendar helpers for the date shifter.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package dadw_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int CNT_W  = 10;
  localparam int STAT_W = 2;
  localparam int WDAY_W = 3;
  localparam int CEN_W  = 7;   // century and year-of-century fields
  localparam int D_W    = 12;  // signed running day, covers 1-1023 .. 31+1023
  localparam int PROD_W = 27;  // year times reciprocal of 100
  localparam int U_W    = 9;   // biased weekday sum, 15..419

  localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
  localparam logic [MON_W-1:0]  MONTHS     = 4'd12;
  localparam logic [CEN_W-1:0]  CEN_LAST   = 7'd99;
  localparam logic [CEN_W-1:0]  HUNDRED    = 7'd100;
  localparam logic [12:0]       RECIP_100  = 13'd5243;  // floor(n/100) = n*5243 >> 19
  localparam int                RECIP_SHIFT = 19;
  localparam logic [9:0]        WDAY_BIAS  = 10'd210;   // multiple of 7, keeps sum positive

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_CHECK,
    S_WALK,
    S_WDAY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic split;
    logic check;
    logic step;
    logic wday;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic walk_fin;
    logic oor;
  } dp_stat_t;

  // Gregorian rule on a year held as century and year of century
  function automatic logic is_leap(input logic [CEN_W-1:0] c, input logic [CEN_W-1:0] yy);
    return ((yy[1:0] == 2'd0) && (yy != '0)) || ((yy == '0) && (c[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // (13*m' - 1) / 5 with m' counted from March
  function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] off;
    case (m)
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dadw_datapath.sv @@
// Datapath of the date shifter: input registers, year split, month walk,
// weekday sum and result registers. Depends on dadw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dadw_datapath #(
  parameter int unsigned MAX_DAY_COUNT = 1000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dadw_pkg::dp_cmd_t                cmd,
  output dadw_pkg::dp_stat_t               stat,
  input  logic                             func,
  input  logic [dadw_pkg::YEAR_W-1:0]      start_year,
  input  logic [dadw_pkg::MON_W-1:0]       start_month,
  input  logic [dadw_pkg::DAY_W-1:0]       start_day,
  input  logic [dadw_pkg::CNT_W-1:0]       day_count,
  output logic                             done,
  output logic [dadw_pkg::STAT_W-1:0]      status,
  output logic [dadw_pkg::YEAR_W-1:0]      result_year,
  output logic [dadw_pkg::MON_W-1:0]       result_month,
  output logic [dadw_pkg::DAY_W-1:0]       result_day,
  output logic [dadw_pkg::WDAY_W-1:0]      weekday
);
  import dadw_pkg::*;

  localparam int unsigned CNT_FULL = (1 << CNT_W) - 1;
  localparam int unsigned CNT_LIM  = (MAX_DAY_COUNT > CNT_FULL) ? CNT_FULL : MAX_DAY_COUNT;

  logic                    sub;
  logic [YEAR_W-1:0]       sy;
  logic [MON_W-1:0]        sm;
  logic [DAY_W-1:0]        sd;
  logic [CNT_W-1:0]        cnt;
  logic [PROD_W-1:0]       prod;
  logic [CEN_W-1:0]        sc, syy;
  logic [CEN_W-1:0]        c, yy;
  logic [MON_W-1:0]        m;
  logic signed [D_W-1:0]   d;
  logic                    oor;
  logic                    bad;
  logic [U_W-1:0]          u;

  // year split
  logic [7:0]              c_full;
  logic [YEAR_W-1:0]       yy_full;

  // walk
  logic [DAY_W-1:0]        len_cur;
  logic signed [D_W-1:0]   len_cur_s;
  logic [MON_W-1:0]        m_prev;
  logic [CEN_W-1:0]        c_prev, yy_prev;
  logic                    wrap_low;
  logic signed [D_W-1:0]   len_prev_s;

  // weekday
  logic                    use_start;
  logic [CEN_W-1:0]        zc, zyy, zc_a, zyy_a;
  logic [MON_W-1:0]        zm;
  logic [DAY_W-1:0]        zd;
  logic [9:0]              v;
  logic [4:0]              s1;
  logic [3:0]              s2;
  logic [WDAY_W-1:0]       wd;

  assign c_full  = prod[RECIP_SHIFT +: 8];
  assign yy_full = sy - YEAR_W'(c_full) * YEAR_W'(HUNDRED);

  assign stat.start_ok = (sy != '0) && (sy <= YEAR_MAX) && (sm != '0) && (sm <= MONTHS) &&
                         (sd != '0) && (sd <= month_len(sm, is_leap(sc, syy)));

  assign len_cur   = month_len(m, is_leap(c, yy));
  assign len_cur_s = signed'(D_W'(len_cur));
  assign stat.walk_fin = sub ? (d > signed'(D_W'(0))) : (d <= len_cur_s);
  assign stat.oor  = oor;

  // previous month, with year borrow
  always_comb begin
    m_prev   = m - 4'd1;
    c_prev   = c;
    yy_prev  = yy;
    wrap_low = 1'b0;
    if (m == 4'd1) begin
      m_prev = MONTHS;
      if (yy == '0) begin
        yy_prev = CEN_LAST;
        c_prev  = c - 7'd1;
      end else begin
        yy_prev = yy - 7'd1;
      end
      wrap_low = (c == '0) && (yy == 7'd1);
    end
  end
  assign len_prev_s = signed'(D_W'(month_len(m_prev, is_leap(c_prev, yy_prev))));

  // Zeller sum: Jan and Feb count as months 11 and 12 of the year before
  always_comb begin
    use_start = bad || oor;
    zc  = use_start ? sc  : c;
    zyy = use_start ? syy : yy;
    zm  = use_start ? sm  : m;
    zd  = use_start ? sd  : d[DAY_W-1:0];
    zc_a  = zc;
    zyy_a = zyy;
    if (zm == 4'd1 || zm == 4'd2) begin
      if (zyy == '0) begin
        zyy_a = CEN_LAST;
        zc_a  = zc - 7'd1;
      end else begin
        zyy_a = zyy - 7'd1;
      end
    end
    v = WDAY_BIAS + 10'(zd) + 10'(month_offset(zm)) + 10'(zyy_a) + 10'(zyy_a >> 2) +
        10'(zc_a >> 2) - {2'b00, zc_a, 1'b0};
  end

  // mod 7 by folding octal digits (8 = 1 mod 7)
  always_comb begin
    s1 = 5'(u[8:6]) + 5'(u[5:3]) + 5'(u[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    wd = (s2 >= 4'd7) ? WDAY_W'(s2 - 4'd7) : WDAY_W'(s2);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sub  <= func;
      sy   <= start_year;
      sm   <= start_month;
      sd   <= start_day;
      cnt  <= (day_count > CNT_W'(CNT_LIM)) ? CNT_W'(CNT_LIM) : day_count;
      prod <= PROD_W'(start_year) * PROD_W'(RECIP_100);
    end
    if (cmd.split) begin
      sc  <= c_full[CEN_W-1:0];
      syy <= yy_full[CEN_W-1:0];
      c   <= c_full[CEN_W-1:0];
      yy  <= yy_full[CEN_W-1:0];
    end
    if (cmd.check) begin
      bad <= !stat.start_ok;
      oor <= 1'b0;
      m   <= sm;
      d   <= sub ? signed'(D_W'(sd) - D_W'(cnt)) : signed'(D_W'(sd) + D_W'(cnt));
    end
    if (cmd.step) begin
      if (sub) begin
        d  <= d + len_prev_s;
        m  <= m_prev;
        c  <= c_prev;
        yy <= yy_prev;
        if (wrap_low) begin
          oor <= 1'b1;
        end
      end else begin
        d <= d - len_cur_s;
        if (m == MONTHS) begin
          m <= 4'd1;
          if (yy == CEN_LAST) begin
            yy <= '0;
            c  <= c + 7'd1;
            if (c == CEN_LAST) begin
              oor <= 1'b1;
            end
          end else begin
            yy <= yy + 7'd1;
          end
        end else begin
          m <= m + 4'd1;
        end
      end
    end
    if (cmd.wday) begin
      u <= v[U_W-1:0];
    end
    if (cmd.emit) begin
      if (bad || oor) begin
        result_year  <= sy;
        result_month <= sm;
        result_day   <= sd;
      end else begin
        result_year  <= YEAR_W'(c) * YEAR_W'(HUNDRED) + YEAR_W'(yy);
        result_month <= m;
        result_day   <= d[DAY_W-1:0];
      end
      status  <= bad ? STAT_BAD : (oor ? STAT_RANGE : STAT_OK);
      weekday <= bad ? '0 : wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dadw_ctrl.sv @@
// Controller of the date shifter: sequences load, split, check, month walk,
// weekday and result. Depends on dadw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dadw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output dadw_pkg::dp_cmd_t   cmd,
  input  dadw_pkg::dp_stat_t  stat
);
  import dadw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.start_ok ? S_WALK : S_EMIT;
      end
      S_WALK: begin
        // one month boundary per cycle; stop early once the year leaves range
        if (stat.walk_fin || stat.oor) begin
          state_next = S_WDAY;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WDAY: begin
        cmd.wday   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/date_add_days_weekday_core.sv @@
// Date shifter top level: adds or subtracts a day count from a Gregorian
// date and returns the new date with its weekday (0 Sunday). An item is taken
// when start is high and busy is low. The month walk crosses one month
// boundary per clock; the weekday and result states follow it, and an
// invalid start date goes from the check straight to the result state.
// done is high for exactly one cycle and the result is kept only until the
// next item's done; a new item may be started in the cycle that done is high.
// A day_count above MAX_DAY_COUNT is clamped to it.
// Depends on dadw_pkg, dadw_ctrl and dadw_datapath.
`timescale 1ns / 1ps
`default_nettype none

module date_add_days_weekday_core #(
  parameter int unsigned MAX_DAY_COUNT = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [dadw_pkg::YEAR_W-1:0]   start_year,
  input  logic [dadw_pkg::MON_W-1:0]    start_month,
  input  logic [dadw_pkg::DAY_W-1:0]    start_day,
  input  logic [dadw_pkg::CNT_W-1:0]    day_count,
  output logic                          done,
  output logic [dadw_pkg::STAT_W-1:0]   status,
  output logic [dadw_pkg::YEAR_W-1:0]   result_year,
  output logic [dadw_pkg::MON_W-1:0]    result_month,
  output logic [dadw_pkg::DAY_W-1:0]    result_day,
  output logic [dadw_pkg::WDAY_W-1:0]   weekday
);
  import dadw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dadw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  dadw_datapath #(
    .MAX_DAY_COUNT (MAX_DAY_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .day_count    (day_count),
    .done         (done),
    .status       (status),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .weekday      (weekday)
  );

endmodule

`default_nettype wire

@@ rtl/dadw_checker.sv @@
// Port-level checks for the date shifter, bound to the top level.
// Depends on dadw_pkg and date_add_days_weekday_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "date_add_days_weekday_core_assert.svh"

module dadw_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [dadw_pkg::STAT_W-1:0]   status,
  input wire logic [dadw_pkg::WDAY_W-1:0]   weekday
);
  import dadw_pkg::*;

  // an accepted word keeps the block busy in the next cycle
  `DADW_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")
  // result strobe only once the walk is over
  `DADW_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "done while busy")
  // invalid start date reports weekday 0
  `DADW_ASSERT_IMP(a_bad_wday, clk, rst, done && (status == STAT_BAD), weekday == '0,
                   "weekday not zero on invalid date")
  // weekday is reduced mod 7 and status is a known code
  `DADW_ASSERT_IMP(a_done_codes, clk, rst, done,
                   (weekday != 3'd7) && (status != 2'd3), "bad weekday or status code")

endmodule

bind date_add_days_weekday_core dadw_checker u_dadw_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .status  (status),
  .weekday (weekday)
);

`default_nettype wire
